// ===== hw/rtl/mmd_pkg.sv =====
package mmd_pkg;

    // register file geometry
    localparam int REG_COUNT  = 32;
    localparam int WORD_W     = 32;
    localparam int REG_FIELD_W = 5;
    localparam logic [REG_FIELD_W-1:0] LINK_REG = 5'd31;
    localparam logic [WORD_W-1:0] WORD_FOUR = 32'd4;

    // operand a source
    localparam logic A_SEL_PC = 1'b0;
    localparam logic A_SEL_RS = 1'b1;

    // write back source
    localparam logic WB_SEL_ALU  = 1'b0;
    localparam logic WB_SEL_LOAD = 1'b1;

    // next pc source
    localparam logic NPC_SEL_ALU  = 1'b0;
    localparam logic NPC_SEL_JUMP = 1'b1;

    // load enable bit positions
    localparam int LD_PC    = 0;
    localparam int LD_MAR   = 1;
    localparam int LD_STORE = 2;
    localparam int LD_IR    = 3;
    localparam int LD_LOAD  = 4;
    localparam int LD_RF    = 5;

    typedef enum logic [2:0] {
        B_SEL_RT,
        B_SEL_ZERO,
        B_SEL_FOUR,
        B_SEL_IMM,
        B_SEL_IMM_X4
    } b_sel_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_XOR
    } alu_op_t;

    typedef enum logic [1:0] {
        WR_SEL_RD,
        WR_SEL_RT,
        WR_SEL_LINK
    } wr_sel_t;

    typedef struct packed {
        logic              a_select;
        logic [2:0]        b_select;
        logic [2:0]        alu_op;
        logic              write_back_select;
        logic              next_pc_select;
        logic [1:0]        write_reg_select;
        logic [5:0]        load_mask;
        logic signed [31:0] memory_data;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] program_counter;
        logic signed [31:0] memory_address;
        logic signed [31:0] store_data;
        logic signed [31:0] instruction;
        logic               zero_flag;
        logic signed [31:0] alu_result;
    } out_beat_t;

    // alu controls handed from the top level
    typedef struct packed {
        logic       a_select;
        logic [2:0] b_select;
        logic [2:0] alu_op;
    } alu_ctrl_t;

endpackage

// ===== hw/rtl/mmd_alu.sv =====
module mmd_alu (
    input  mmd_pkg::alu_ctrl_t            ctrl,
    input  logic [mmd_pkg::WORD_W-1:0]    pc,
    input  logic [mmd_pkg::WORD_W-1:0]    rs_val,
    input  logic [mmd_pkg::WORD_W-1:0]    rt_val,
    input  logic [15:0]                   imm,
    output logic [mmd_pkg::WORD_W-1:0]    result
);

    logic [mmd_pkg::WORD_W-1:0] opa;
    logic [mmd_pkg::WORD_W-1:0] opb;
    logic [mmd_pkg::WORD_W-1:0] imm_sext;

    assign imm_sext = {{16{imm[15]}}, imm};
    assign opa = (ctrl.a_select == mmd_pkg::A_SEL_RS) ? rs_val : pc;

    always_comb begin
        case (ctrl.b_select)
            mmd_pkg::B_SEL_RT:     opb = rt_val;
            mmd_pkg::B_SEL_ZERO:   opb = '0;
            mmd_pkg::B_SEL_FOUR:   opb = mmd_pkg::WORD_FOUR;
            mmd_pkg::B_SEL_IMM:    opb = imm_sext;
            mmd_pkg::B_SEL_IMM_X4: opb = {imm_sext[29:0], 2'b00};
            default:               opb = '0;
        endcase
    end

    always_comb begin
        case (ctrl.alu_op)
            mmd_pkg::ALU_ADD: result = opa + opb;
            mmd_pkg::ALU_SUB: result = opa - opb;
            mmd_pkg::ALU_AND: result = opa & opb;
            mmd_pkg::ALU_OR:  result = opa | opb;
            mmd_pkg::ALU_XOR: result = opa ^ opb;
            default:          result = '0;
        endcase
    end

endmodule

// ===== hw/rtl/mmd_regfile.sv =====
module mmd_regfile #(
    parameter int REG_COUNT = mmd_pkg::REG_COUNT,
    localparam int AddrW = $clog2(REG_COUNT)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [AddrW-1:0]              rd_addr_a,
    input  logic [AddrW-1:0]              rd_addr_b,
    input  logic                          wr_en,
    input  logic [AddrW-1:0]              wr_addr,
    input  logic [mmd_pkg::WORD_W-1:0]    wr_data,
    output logic [mmd_pkg::WORD_W-1:0]    rd_data_a,
    output logic [mmd_pkg::WORD_W-1:0]    rd_data_b
);

    logic [mmd_pkg::WORD_W-1:0] mem [REG_COUNT];
    logic [REG_COUNT-1:0]       valid_reg;
    logic [mmd_pkg::WORD_W-1:0] mem_a_reg;
    logic [mmd_pkg::WORD_W-1:0] mem_b_reg;
    logic [mmd_pkg::WORD_W-1:0] wdata_reg;
    logic                       valid_a_reg;
    logic                       valid_b_reg;
    logic                       hit_a_reg;
    logic                       hit_b_reg;

    // storage and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_a_reg <= mem[rd_addr_a];
            mem_b_reg <= mem[rd_addr_b];
            wdata_reg <= wr_data;
        end
    end

    // valid bits and same-edge write bypass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            hit_a_reg   <= 1'b0;
            hit_b_reg   <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                valid_a_reg <= valid_reg[rd_addr_a];
                valid_b_reg <= valid_reg[rd_addr_b];
                hit_a_reg   <= wr_en && (wr_addr == rd_addr_a);
                hit_b_reg   <= wr_en && (wr_addr == rd_addr_b);
            end
        end
    end

    assign rd_data_a = hit_a_reg ? wdata_reg : (valid_a_reg ? mem_a_reg : '0);
    assign rd_data_b = hit_b_reg ? wdata_reg : (valid_b_reg ? mem_b_reg : '0);

endmodule

// ===== hw/rtl/multicycle_mips_datapath_top.sv =====
// Multicycle MIPS-style datapath. Each input beat is one clock step of the controller: operand
// and ALU selects, next-pc and write-back selects, six load enables and the word read from
// memory. The step is formed from the datapath registers as they stand, the enabled registers
// load, the zero flag always loads, and one result beat follows carrying pc, memory address,
// store data and instruction registers after the step plus the step's ALU result and zero
// flag. One beat is taken every clock in which no result waits or the waiting result is taken;
// its result appears in the output register on the next cycle. The rate is set by the single
// path from the registered register-file read through operand select and the ALU into the
// datapath registers. The register file reads as all zeros after reset through per-entry valid
// bits, so no clearing pass is needed; register 0 is never written.
module multicycle_mips_datapath_top #(
    parameter int REG_COUNT = mmd_pkg::REG_COUNT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mmd_pkg::in_beat_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mmd_pkg::out_beat_t m_data
);

    localparam int AddrW = $clog2(REG_COUNT);
    localparam int W = mmd_pkg::WORD_W;

    // datapath registers, which also serve as the result register
    logic [W-1:0] pc_reg,      pc_next;
    logic [W-1:0] address_reg, address_next;
    logic [W-1:0] store_reg,   store_next;
    logic [W-1:0] instr_reg,   instr_next;
    logic [W-1:0] load_reg,    load_next;
    logic         zero_reg,    zero_next;
    logic [W-1:0] alu_out_reg;
    logic         m_valid_reg, m_valid_next;

    logic         s_fire;
    logic [W-1:0] rs_val;
    logic [W-1:0] rt_val;
    logic [W-1:0] alu_res;
    logic [W-1:0] jump_target;
    logic [W-1:0] wr_data;
    logic [mmd_pkg::REG_FIELD_W-1:0] wr_field;
    logic         wr_en;
    logic [5:0]   ld;
    mmd_pkg::alu_ctrl_t alu_ctrl;

    // take a beat whenever the result slot is empty or being drained
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign ld      = s_data.load_mask;

    assign alu_ctrl.a_select = s_data.a_select;
    assign alu_ctrl.b_select = s_data.b_select;
    assign alu_ctrl.alu_op   = s_data.alu_op;

    mmd_alu u_alu (
        .ctrl   (alu_ctrl),
        .pc     (pc_reg),
        .rs_val (rs_val),
        .rt_val (rt_val),
        .imm    (instr_reg[15:0]),
        .result (alu_res)
    );

    // jump target keeps the top nibble of pc
    assign jump_target = {pc_reg[31:28], instr_reg[25:0], 2'b00};

    assign wr_data = (s_data.write_back_select == mmd_pkg::WB_SEL_LOAD) ? load_reg : alu_res;

    always_comb begin
        case (s_data.write_reg_select)
            mmd_pkg::WR_SEL_RD:   wr_field = instr_reg[15:11];
            mmd_pkg::WR_SEL_RT:   wr_field = instr_reg[20:16];
            mmd_pkg::WR_SEL_LINK: wr_field = mmd_pkg::LINK_REG;
            default:              wr_field = '0;
        endcase
    end

    // writes to register zero are dropped
    assign wr_en = s_fire && ld[mmd_pkg::LD_RF] && (wr_field != '0);

    always_comb begin
        pc_next      = pc_reg;
        address_next = address_reg;
        store_next   = store_reg;
        instr_next   = instr_reg;
        load_next    = load_reg;
        zero_next    = zero_reg;
        if (s_fire) begin
            zero_next = (alu_res == '0);
            if (ld[mmd_pkg::LD_PC]) begin
                pc_next = (s_data.next_pc_select == mmd_pkg::NPC_SEL_JUMP) ? jump_target
                                                                           : alu_res;
            end
            if (ld[mmd_pkg::LD_MAR]) begin
                address_next = alu_res;
            end
            if (ld[mmd_pkg::LD_STORE]) begin
                store_next = rt_val;
            end
            if (ld[mmd_pkg::LD_IR]) begin
                instr_next = s_data.memory_data;
            end
            if (ld[mmd_pkg::LD_LOAD]) begin
                load_next = s_data.memory_data;
            end
        end
    end

    always_comb begin
        if (s_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // register file reads are addressed by the instruction that will stand after this edge
    mmd_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_fire),
        .rd_addr_a (AddrW'(instr_next[25:21])),
        .rd_addr_b (AddrW'(instr_next[20:16])),
        .wr_en     (wr_en),
        .wr_addr   (AddrW'(wr_field)),
        .wr_data   (wr_data),
        .rd_data_a (rs_val),
        .rd_data_b (rt_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= '0;
            address_reg <= '0;
            store_reg   <= '0;
            instr_reg   <= '0;
            load_reg    <= '0;
            zero_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            address_reg <= address_next;
            store_reg   <= store_next;
            instr_reg   <= instr_next;
            load_reg    <= load_next;
            zero_reg    <= zero_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // alu result is payload only
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            alu_out_reg <= alu_res;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_data.program_counter = pc_reg;
    assign m_data.memory_address  = address_reg;
    assign m_data.store_data      = store_reg;
    assign m_data.instruction     = instr_reg;
    assign m_data.zero_flag       = zero_reg;
    assign m_data.alu_result      = alu_out_reg;

`ifndef SYNTHESIS
    // register zero always reads as zero on the rs port
    a_rs_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (instr_reg[25:21] == 5'd0) |-> (rs_val == '0))
        else $error("register zero read nonzero on rs port");

    // every accepted beat leaves a result waiting
    a_fire_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid)
        else $error("accepted beat produced no result");

    // zero flag agrees with the shown alu result
    a_zero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.zero_flag == (m_data.alu_result == '0)))
        else $error("zero flag does not match alu result");

    // datapath state moves only on an accepted beat
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> ($stable(pc_reg) && $stable(instr_reg) && $stable(address_reg)))
        else $error("datapath state changed without a beat");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // spare select codes the decoder must still tolerate
    localparam logic [2:0] B_SEL_SPARE5 = 3'd5;
    localparam logic [2:0] B_SEL_SPARE7 = 3'd7;
    localparam logic [2:0] ALU_SPARE5   = 3'd5;
    localparam logic [2:0] ALU_SPARE6   = 3'd6;
    localparam logic [2:0] ALU_SPARE7   = 3'd7;
    localparam logic [1:0] WR_SEL_SPARE = 2'd3;

    // load enable masks
    localparam logic [5:0] M_NONE  = 6'd0;
    localparam logic [5:0] M_PC    = 6'(1 << mmd_pkg::LD_PC);
    localparam logic [5:0] M_MAR   = 6'(1 << mmd_pkg::LD_MAR);
    localparam logic [5:0] M_STORE = 6'(1 << mmd_pkg::LD_STORE);
    localparam logic [5:0] M_IR    = 6'(1 << mmd_pkg::LD_IR);
    localparam logic [5:0] M_LOAD  = 6'(1 << mmd_pkg::LD_LOAD);
    localparam logic [5:0] M_RF    = 6'(1 << mmd_pkg::LD_RF);
    localparam logic [5:0] M_ALL   = M_PC | M_MAR | M_STORE | M_IR | M_LOAD | M_RF;

    localparam int N_RANDOM     = 1225;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4;

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    // one step of the controller, with its expected beat where it is typed in
    typedef struct {
        mmd_pkg::in_beat_t  beat;
        bit                 typed;
        mmd_pkg::out_beat_t want;
    } step_row_t;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    mmd_pkg::in_beat_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    mmd_pkg::out_beat_t m_data;

    // shadow copy of the datapath registers
    logic [31:0] pc_q, mar_q, sdr_q, ir_q, ldr_q;
    logic [31:0] regs [mmd_pkg::REG_COUNT];

    step_row_t          steps[$];
    mmd_pkg::out_beat_t results_due[$];
    int                 accepted = 0;
    int                 errors   = 0;

    multicycle_mips_datapath_top #(
        .REG_COUNT(mmd_pkg::REG_COUNT)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic mmd_pkg::in_beat_t make_beat(input logic a_sel,
                                                    input logic [2:0] b_sel,
                                                    input logic [2:0] op, input logic wb_sel,
                                                    input logic npc_sel,
                                                    input logic [1:0] wr_sel,
                                                    input logic [5:0] mask,
                                                    input logic [31:0] mem);
        mmd_pkg::in_beat_t b;
        b.a_select          = a_sel;
        b.b_select          = b_sel;
        b.alu_op            = op;
        b.write_back_select = wb_sel;
        b.next_pc_select    = npc_sel;
        b.write_reg_select  = wr_sel;
        b.load_mask         = mask;
        b.memory_data       = mem;
        return b;
    endfunction

    function automatic mmd_pkg::out_beat_t make_regs(input logic [31:0] pc,
                                                     input logic [31:0] mar,
                                                     input logic [31:0] sd,
                                                     input logic [31:0] ir,
                                                     input logic zf,
                                                     input logic [31:0] alu);
        mmd_pkg::out_beat_t r;
        r.program_counter = pc;
        r.memory_address  = mar;
        r.store_data      = sd;
        r.instruction     = ir;
        r.zero_flag       = zf;
        r.alu_result      = alu;
        return r;
    endfunction

    task automatic add_row(input mmd_pkg::in_beat_t beat, input bit typed,
                           input mmd_pkg::out_beat_t want);
        step_row_t row;
        row.beat  = beat;
        row.typed = typed;
        row.want  = want;
        steps.push_back(row);
    endtask

    // one clock step of the datapath on the shadow registers
    function automatic mmd_pkg::out_beat_t step_datapath(input mmd_pkg::in_beat_t b);
        logic [31:0] rs_val, rt_val, imm, op_a, op_b, alu, next_pc, wdata;
        logic [4:0]  waddr;
        rs_val = regs[ir_q[25:21]];
        rt_val = regs[ir_q[20:16]];
        imm    = {{16{ir_q[15]}}, ir_q[15:0]};
        op_a   = (b.a_select == mmd_pkg::A_SEL_RS) ? rs_val : pc_q;
        case (b.b_select)
            mmd_pkg::B_SEL_RT:     op_b = rt_val;
            mmd_pkg::B_SEL_ZERO:   op_b = '0;
            mmd_pkg::B_SEL_FOUR:   op_b = mmd_pkg::WORD_FOUR;
            mmd_pkg::B_SEL_IMM:    op_b = imm;
            mmd_pkg::B_SEL_IMM_X4: op_b = {imm[29:0], 2'b00};
            default:               op_b = '0;
        endcase
        case (b.alu_op)
            mmd_pkg::ALU_ADD: alu = op_a + op_b;
            mmd_pkg::ALU_SUB: alu = op_a - op_b;
            mmd_pkg::ALU_AND: alu = op_a & op_b;
            mmd_pkg::ALU_OR:  alu = op_a | op_b;
            mmd_pkg::ALU_XOR: alu = op_a ^ op_b;
            default:          alu = '0;
        endcase
        next_pc = (b.next_pc_select == mmd_pkg::NPC_SEL_JUMP)
                ? {pc_q[31:28], ir_q[25:0], 2'b00} : alu;
        wdata   = (b.write_back_select == mmd_pkg::WB_SEL_LOAD) ? ldr_q : alu;
        case (b.write_reg_select)
            mmd_pkg::WR_SEL_RD:   waddr = ir_q[15:11];
            mmd_pkg::WR_SEL_RT:   waddr = ir_q[20:16];
            mmd_pkg::WR_SEL_LINK: waddr = mmd_pkg::LINK_REG;
            default:              waddr = '0;
        endcase
        if (b.load_mask[mmd_pkg::LD_PC])    pc_q  = next_pc;
        if (b.load_mask[mmd_pkg::LD_MAR])   mar_q = alu;
        if (b.load_mask[mmd_pkg::LD_STORE]) sdr_q = rt_val;
        if (b.load_mask[mmd_pkg::LD_IR])    ir_q  = b.memory_data;
        if (b.load_mask[mmd_pkg::LD_LOAD])  ldr_q = b.memory_data;
        if (b.load_mask[mmd_pkg::LD_RF] && waddr != '0) regs[waddr] = wdata;
        return make_regs(pc_q, mar_q, sdr_q, ir_q, alu == '0, alu);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endtask

    // scoreboard: predict on every accepted input beat, check every accepted result beat
    always @(posedge aclk) begin
        mmd_pkg::out_beat_t pred, want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pred = step_datapath(s_data);
                // a typed-in row is held to its own value, the predictor still advances
                results_due.push_back(steps[accepted].typed ? steps[accepted].want : pred);
                accepted++;
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    want = results_due.pop_front();
                    check_field("program_counter", want.program_counter, m_data.program_counter);
                    check_field("memory_address", want.memory_address, m_data.memory_address);
                    check_field("store_data", want.store_data, m_data.store_data);
                    check_field("instruction", want.instruction, m_data.instruction);
                    check_field("zero_flag", 32'(want.zero_flag), 32'(m_data.zero_flag));
                    check_field("alu_result", want.alu_result, m_data.alu_result);
                end
            end
        end
    end

    // receiver: changing stall patterns, plus one long hold-off that backs up the input
    initial begin : receiver
        rx_mode_t mode;
        int       len;
        bit       held;
        held = 1'b0;
        wait (aresetn);
        forever begin
            if (!held && accepted >= HOLD_AFTER) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge aclk);
                    m_ready = 1'b0;
                end
            end
            mode = rx_mode_t'($urandom_range(0, 3));
            len  = $urandom_range(16, 120);
            for (int i = 0; i < len; i++) begin
                @(negedge aclk);
                case (mode)
                    RX_OPEN:   m_ready = 1'b1;
                    RX_COIN:   m_ready = 1'($urandom_range(0, 1));
                    RX_SPARSE: m_ready = ($urandom_range(0, 3) == 0);
                    default:   m_ready = (i % 3 == 0);
                endcase
            end
        end
    end

    // run limit, far above the slowest legal run
    initial begin
        #2_000_000;
        $display("FAIL multicycle_mips_datapath_top");
        $finish;
    end

    initial begin : main
        int n_rand, idx, burst, gap, kind;
        logic [5:0] extra;

        for (int r = 0; r < mmd_pkg::REG_COUNT; r++) regs[r] = '0;
        pc_q  = '0;
        mar_q = '0;
        sdr_q = '0;
        ir_q  = '0;
        ldr_q = '0;

        // directed table
        // after reset everything reads zero and the flag is set
        add_row(make_beat(mmd_pkg::A_SEL_PC, mmd_pkg::B_SEL_ZERO, mmd_pkg::ALU_ADD,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_NONE, 32'h0000_0000), 1'b1, make_regs(0, 0, 0, 0, 1'b1, 0));
        // fetch of the largest positive word, pc steps by four
        add_row(make_beat(mmd_pkg::A_SEL_PC, mmd_pkg::B_SEL_FOUR, mmd_pkg::ALU_ADD,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_PC | M_IR, 32'h7FFF_FFFF), 1'b1,
                make_regs(4, 0, 0, 32'h7FFF_FFFF, 1'b0, 4));
        // most negative word into ir, pc minus four gives zero
        add_row(make_beat(mmd_pkg::A_SEL_PC, mmd_pkg::B_SEL_FOUR, mmd_pkg::ALU_SUB,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_IR, 32'h8000_0000), 1'b1,
                make_regs(4, 0, 0, 32'h8000_0000, 1'b1, 0));
        // ir with rs 1, rt 2, rd 16, negative immediate; also into the load register
        add_row(make_beat(mmd_pkg::A_SEL_PC, mmd_pkg::B_SEL_FOUR, mmd_pkg::ALU_ADD,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_IR | M_LOAD, 32'h0022_8004), 1'b0, '0);
        // write rt, rd from the load register, the link register, and the spare destination
        add_row(make_beat(mmd_pkg::A_SEL_PC, mmd_pkg::B_SEL_FOUR, mmd_pkg::ALU_ADD,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RT,
                          M_RF | M_PC, 32'h0), 1'b0, '0);
        add_row(make_beat(mmd_pkg::A_SEL_PC, mmd_pkg::B_SEL_ZERO, mmd_pkg::ALU_ADD,
                          mmd_pkg::WB_SEL_LOAD, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_RF, 32'h0), 1'b0, '0);
        add_row(make_beat(mmd_pkg::A_SEL_PC, mmd_pkg::B_SEL_FOUR, mmd_pkg::ALU_ADD,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_LINK,
                          M_RF, 32'h0), 1'b0, '0);
        add_row(make_beat(mmd_pkg::A_SEL_PC, mmd_pkg::B_SEL_FOUR, mmd_pkg::ALU_ADD,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, WR_SEL_SPARE,
                          M_RF, 32'h0), 1'b0, '0);
        // ir with rs 2, rt 16 so both operands are live
        add_row(make_beat(mmd_pkg::A_SEL_PC, mmd_pkg::B_SEL_ZERO, mmd_pkg::ALU_OR,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_IR, 32'h0050_8004), 1'b0, '0);
        // every alu function on rs and rt
        add_row(make_beat(mmd_pkg::A_SEL_RS, mmd_pkg::B_SEL_RT, mmd_pkg::ALU_ADD,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_MAR | M_STORE, 32'h0), 1'b0, '0);
        add_row(make_beat(mmd_pkg::A_SEL_RS, mmd_pkg::B_SEL_RT, mmd_pkg::ALU_SUB,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_MAR | M_STORE, 32'h0), 1'b0, '0);
        add_row(make_beat(mmd_pkg::A_SEL_RS, mmd_pkg::B_SEL_RT, mmd_pkg::ALU_AND,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_MAR | M_STORE, 32'h0), 1'b0, '0);
        add_row(make_beat(mmd_pkg::A_SEL_RS, mmd_pkg::B_SEL_RT, mmd_pkg::ALU_OR,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_MAR | M_STORE, 32'h0), 1'b0, '0);
        add_row(make_beat(mmd_pkg::A_SEL_RS, mmd_pkg::B_SEL_RT, mmd_pkg::ALU_XOR,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_MAR | M_STORE, 32'h0), 1'b0, '0);
        // spare alu functions give zero
        add_row(make_beat(mmd_pkg::A_SEL_RS, mmd_pkg::B_SEL_RT, ALU_SPARE5,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_MAR, 32'h0), 1'b0, '0);
        add_row(make_beat(mmd_pkg::A_SEL_RS, mmd_pkg::B_SEL_RT, ALU_SPARE6,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_MAR, 32'h0), 1'b0, '0);
        add_row(make_beat(mmd_pkg::A_SEL_RS, mmd_pkg::B_SEL_RT, ALU_SPARE7,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_MAR, 32'h0), 1'b0, '0);
        // spare operand b codes give zero
        add_row(make_beat(mmd_pkg::A_SEL_RS, B_SEL_SPARE5, mmd_pkg::ALU_ADD,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_MAR, 32'h0), 1'b0, '0);
        add_row(make_beat(mmd_pkg::A_SEL_RS, B_SEL_SPARE7, mmd_pkg::ALU_ADD,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_MAR, 32'h0), 1'b0, '0);
        // immediate, immediate times four, and a jump
        add_row(make_beat(mmd_pkg::A_SEL_PC, mmd_pkg::B_SEL_IMM, mmd_pkg::ALU_ADD,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_MAR, 32'h0), 1'b0, '0);
        add_row(make_beat(mmd_pkg::A_SEL_PC, mmd_pkg::B_SEL_IMM_X4, mmd_pkg::ALU_ADD,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_JUMP, mmd_pkg::WR_SEL_RD,
                          M_MAR | M_PC, 32'h0), 1'b0, '0);
        // write to register zero is dropped, read back through rs and rt
        add_row(make_beat(mmd_pkg::A_SEL_PC, mmd_pkg::B_SEL_ZERO, mmd_pkg::ALU_ADD,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_IR, 32'h0), 1'b0, '0);
        add_row(make_beat(mmd_pkg::A_SEL_PC, mmd_pkg::B_SEL_FOUR, mmd_pkg::ALU_ADD,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RT,
                          M_RF, 32'h0), 1'b0, '0);
        add_row(make_beat(mmd_pkg::A_SEL_RS, mmd_pkg::B_SEL_RT, mmd_pkg::ALU_ADD,
                          mmd_pkg::WB_SEL_ALU, mmd_pkg::NPC_SEL_ALU, mmd_pkg::WR_SEL_RD,
                          M_MAR | M_STORE, 32'h0), 1'b0, '0);
        // all loads at once with an all-ones word
        add_row(make_beat(mmd_pkg::A_SEL_RS, mmd_pkg::B_SEL_RT, mmd_pkg::ALU_XOR,
                          mmd_pkg::WB_SEL_LOAD, mmd_pkg::NPC_SEL_JUMP, mmd_pkg::WR_SEL_LINK,
                          M_ALL, 32'hFFFF_FFFF), 1'b0, '0);

        // random part: mostly fetch / decode / execute / write-back sequences, some noise
        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            kind = $urandom_range(0, 3);
            if (kind != 0) begin
                // fetch: pc plus four, new instruction word
                add_row(make_beat(mmd_pkg::A_SEL_PC, mmd_pkg::B_SEL_FOUR, mmd_pkg::ALU_ADD,
                                  1'($urandom_range(0, 1)), mmd_pkg::NPC_SEL_ALU,
                                  2'($urandom_range(0, 2)), M_PC | M_IR, $urandom),
                        1'b0, '0);
                // decode: branch target into mar, rt into store data
                add_row(make_beat(mmd_pkg::A_SEL_PC, mmd_pkg::B_SEL_IMM_X4, mmd_pkg::ALU_ADD,
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  2'($urandom_range(0, 2)), M_MAR | M_STORE, $urandom),
                        1'b0, '0);
                // execute on rs with a random operand and function
                extra = $urandom_range(0, 1) ? M_LOAD : M_NONE;
                add_row(make_beat(mmd_pkg::A_SEL_RS, 3'($urandom_range(0, 4)),
                                  3'($urandom_range(0, 4)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  2'($urandom_range(0, 2)), M_MAR | extra, $urandom),
                        1'b0, '0);
                // write-back, sometimes with a pc update or jump
                extra = $urandom_range(0, 1) ? M_PC : M_NONE;
                add_row(make_beat(1'($urandom_range(0, 1)), 3'($urandom_range(0, 4)),
                                  3'($urandom_range(0, 4)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 2'($urandom_range(0, 2)),
                                  M_RF | extra, $urandom), 1'b0, '0);
                n_rand += 4;
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    add_row(make_beat(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                      3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                      6'($urandom_range(0, 63)), $urandom), 1'b0, '0);
                    n_rand++;
                end
            end
        end

        // reset, released on a falling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // sender: bursts of random length with random gaps, some gaps of zero
        idx = 0;
        while (idx < steps.size()) begin
            burst = $urandom_range(1, 24);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            for (int k = 0; k < burst && idx < steps.size(); k++) begin
                @(negedge aclk);
                s_valid = 1'b1;
                s_data  = steps[idx].beat;
                do @(posedge aclk); while (!s_ready);
                idx++;
            end
            repeat (gap) begin
                @(negedge aclk);
                s_valid = 1'b0;
            end
        end
        @(negedge aclk);
        s_valid = 1'b0;

        // drain, then keep the clock running to catch stray beats
        while (results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("PASS multicycle_mips_datapath_top");
        end else begin
            $display("FAIL multicycle_mips_datapath_top");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/mmd_pkg.sv
hw/rtl/mmd_alu.sv
hw/rtl/mmd_regfile.sv
hw/rtl/multicycle_mips_datapath_top.sv
bench/tb.sv
